>>> hdl/gab_pkg.sv
// ----------------------------------------------------------------------------
// gab_pkg
// Shared types and constants for the GEMM alpha/bias engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gab_pkg;

   // default largest matrix dimension
   localparam int DEFAULT_MAX_DIM = 16;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_LEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_BY_ROW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_BY_COL = 3'd5;

   // request kinds
   localparam logic [1:0] KIND_LOAD_A   = 2'd0;
   localparam logic [1:0] KIND_LOAD_B   = 2'd1;
   localparam logic [1:0] KIND_LOAD_BIAS = 2'd2;
   localparam logic [1:0] KIND_COMPUTE  = 2'd3;

   // register file
   typedef struct packed {
      logic [4:0]         rows_a;
      logic [4:0]         inner_len;
      logic [4:0]         cols_b;
      logic signed [15:0] alpha_gain;
      logic               bias_by_row;
      logic               bias_by_col;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rows_a:      5'd16,
      inner_len:   5'd16,
      cols_b:      5'd16,
      alpha_gain:  16'sd256,
      bias_by_row: 1'b0,
      bias_by_col: 1'b1
   };

   // tag that travels with each memory read down the MAC pipeline
   typedef struct packed {
      logic       valid;
      logic       first_k;
      logic       last_k;
      logic       last_col;
      logic [3:0] row;
      logic [3:0] col;
   } tag_type;

endpackage

`default_nettype wire

>>> hdl/gab_req_if.sv
// ----------------------------------------------------------------------------
// gab_req_if
// Request channel: load an element or start a row computation.
// ----------------------------------------------------------------------------
`default_nettype none

interface gab_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [7:0]         index;
   logic signed [15:0] value;

   modport source (output valid, kind, index, value, input ready);
   modport sink   (input valid, kind, index, value, output ready);
endinterface

`default_nettype wire

>>> hdl/gab_rsp_if.sv
// ----------------------------------------------------------------------------
// gab_rsp_if
// Result channel: one result element per column of a computed row.
// ----------------------------------------------------------------------------
`default_nettype none

interface gab_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         out_row;
   logic [3:0]         out_col;
   logic signed [31:0] out_value;
   logic               saturated;
   logic               last;

   modport source (output valid, out_row, out_col, out_value, saturated, last,
                   input ready);
   modport sink   (input valid, out_row, out_col, out_value, saturated, last,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/gab_ram.sv
// ----------------------------------------------------------------------------
// gab_ram
// Simple dual-port element store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gab_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [15:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [15:0]       rd_data
);

   logic [15:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hdl/gab_ctrl.sv
// ----------------------------------------------------------------------------
// gab_ctrl
// Row sequencer: walks columns and inner index, issues store reads and tags.
// ----------------------------------------------------------------------------
`default_nettype none

module gab_ctrl #(
   parameter int MAX_DIM = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  run,
   input  wire gab_pkg::cfg_type                      cfg,
   input  wire logic                                  req_fire,
   input  wire logic [1:0]                            req_kind,
   input  wire logic [7:0]                            req_index,
   output logic                                       req_ready,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]         a_addr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]         b_addr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]         bias_addr,
   output gab_pkg::tag_type                           tag
);
   import gab_pkg::*;

   localparam int CW = $clog2(MAX_DIM);
   localparam int NW = $clog2(MAX_DIM + 1);
   localparam int AW = $clog2(MAX_DIM * MAX_DIM);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] c_ff, c_in;
   logic [NW-1:0] n_rows, n_inner, n_cols;
   logic [CW-1:0] bias_row, bias_col;
   logic          k_last, c_last, start;

   // zero counts as one, anything above MAX_DIM as MAX_DIM
   function automatic logic [NW-1:0] clamp_dim(input logic [4:0] d);
      logic [NW-1:0] r;
      if (d == 5'd0) begin
         r = NW'(1);
      end else if (32'(d) > 32'(MAX_DIM)) begin
         r = NW'(MAX_DIM);
      end else begin
         r = NW'(d);
      end
      return r;
   endfunction

   assign n_rows  = clamp_dim(cfg.rows_a);
   assign n_inner = clamp_dim(cfg.inner_len);
   assign n_cols  = clamp_dim(cfg.cols_b);

   assign k_last    = (32'(k_ff) + 32'd1) == 32'(n_inner);
   assign c_last    = (32'(c_ff) + 32'd1) == 32'(n_cols);
   assign req_ready = (state_ff == ST_IDLE);
   // out-of-range row gives no results
   assign start     = req_fire && (req_kind == KIND_COMPUTE) &&
                      (32'(req_index) < 32'(n_rows));

   // sequencer
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      k_in     = k_ff;
      c_in     = c_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               row_in   = CW'(req_index);
               k_in     = '0;
               c_in     = '0;
            end
         end
         ST_RUN: begin
            if (run) begin
               if (k_last) begin
                  k_in = '0;
                  if (c_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     c_in = c_ff + CW'(1);
                  end
               end else begin
                  k_in = k_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         k_ff     <= '0;
         c_ff     <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         k_ff     <= k_in;
         c_ff     <= c_in;
      end
   end

   // store addresses, element (r,c) at r*MAX_DIM+c
   assign bias_row  = cfg.bias_by_row ? row_ff : '0;
   assign bias_col  = cfg.bias_by_col ? c_ff : '0;
   assign a_addr    = AW'(32'(row_ff) * MAX_DIM + 32'(k_ff));
   assign b_addr    = AW'(32'(k_ff) * MAX_DIM + 32'(c_ff));
   assign bias_addr = AW'(32'(bias_row) * MAX_DIM + 32'(bias_col));

   // tag for this read
   always_comb begin
      tag.valid    = (state_ff == ST_RUN);
      tag.first_k  = (k_ff == '0);
      tag.last_k   = k_last;
      tag.last_col = c_last;
      tag.row      = 4'(row_ff);
      tag.col      = 4'(c_ff);
   end

endmodule

`default_nettype wire

>>> hdl/gab_mac.sv
// ----------------------------------------------------------------------------
// gab_mac
// Multiply-accumulate pipeline with alpha scaling, bias add, clipping and
// the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gab_mac #(
   parameter int MAX_DIM = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic signed [15:0] alpha_gain,
   input  wire gab_pkg::tag_type   tag_in,
   input  wire logic [15:0]        a_rd,
   input  wire logic [15:0]        b_rd,
   input  wire logic [15:0]        bias_rd,
   output logic                    run,
   gab_rsp_if.source               rsp_bus
);
   import gab_pkg::*;

   localparam int DOT_W = 32 + $clog2(MAX_DIM);
   localparam int SCL_W = DOT_W + 16;
   localparam int SUM_W = DOT_W + 9;
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

   tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag4_in;
   logic [15:0] bias2_ff, bias3_ff, bias4_ff;
   logic signed [31:0]    prod_ff, prod_in;
   logic signed [DOT_W-1:0] acc_ff, acc_in;
   logic signed [SCL_W-1:0] scaled_ff, scaled_in;
   logic signed [SCL_W-9:0] scaled_q16;
   logic signed [23:0]      bias_q16;
   logic signed [SUM_W-1:0] sum;
   logic                    rsp_valid_ff;
   logic [3:0]              rsp_row_ff, rsp_col_ff;
   logic signed [31:0]      rsp_value_ff, rsp_value_in;
   logic                    rsp_sat_ff, rsp_sat_in, rsp_last_ff;

   // whole pipeline moves unless the output holds an untaken result
   assign run = !rsp_valid_ff || rsp_bus.ready;

   // only the last inner step of a column carries a result
   always_comb begin
      tag4_in       = tag3_ff;
      tag4_in.valid = tag3_ff.valid && tag3_ff.last_k;
   end

   // tags
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         tag4_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (run) begin
         tag1_ff      <= tag_in;
         tag2_ff      <= tag1_ff;
         tag3_ff      <= tag2_ff;
         tag4_ff      <= tag4_in;
         rsp_valid_ff <= tag4_ff.valid;
      end
   end

   // product, accumulate, scale
   assign prod_in   = 32'($signed(a_rd)) * 32'($signed(b_rd));
   assign acc_in    = tag2_ff.first_k ? DOT_W'(prod_ff) : acc_ff + DOT_W'(prod_ff);
   assign scaled_in = SCL_W'(alpha_gain) * SCL_W'(acc_ff);

   always_ff @(posedge clock) begin
      if (run) begin
         prod_ff   <= prod_in;
         bias2_ff  <= bias_rd;
         bias3_ff  <= bias2_ff;
         bias4_ff  <= bias3_ff;
         scaled_ff <= scaled_in;
         if (tag2_ff.valid) begin
            acc_ff <= acc_in;
         end
      end
   end

   // floor shift to Q16.16, add bias, clip to 32 bits
   assign scaled_q16 = (SCL_W-8)'(scaled_ff >>> 8);
   assign bias_q16   = $signed({bias4_ff, 8'h00});
   assign sum        = SUM_W'(scaled_q16) + SUM_W'(bias_q16);

   always_comb begin
      if (sum > SAT_HI) begin
         rsp_value_in = 32'sh7fff_ffff;
         rsp_sat_in   = 1'b1;
      end else if (sum < SAT_LO) begin
         rsp_value_in = 32'sh8000_0000;
         rsp_sat_in   = 1'b1;
      end else begin
         rsp_value_in = 32'(sum);
         rsp_sat_in   = 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (run) begin
         rsp_row_ff   <= tag4_ff.row;
         rsp_col_ff   <= tag4_ff.col;
         rsp_value_ff <= rsp_value_in;
         rsp_sat_ff   <= rsp_sat_in;
         rsp_last_ff  <= tag4_ff.last_col;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_row   = rsp_row_ff;
   assign rsp_bus.out_col   = rsp_col_ff;
   assign rsp_bus.out_value = rsp_value_ff;
   assign rsp_bus.saturated = rsp_sat_ff;
   assign rsp_bus.last      = rsp_last_ff;

endmodule

`default_nettype wire

>>> hdl/gemm_alpha_bias_engine_unit.sv
// ----------------------------------------------------------------------------
// gemm_alpha_bias_engine_unit
// Fixed-point matrix multiply with alpha scale and broadcast bias.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries load and compute requests. Loads (kind A, B or bias) write
//   one Q8.8 element at address row*MAX_DIM+col and are taken one per cycle
//   while no row computes; a load with an address past the store is dropped.
//   A compute request names a row; for each column the block returns alpha
//   times the dot product plus bias on rsp_bus as Q16.16, clipped to 32 bits
//   with a saturation flag, last set on the final column.
//   Compute: a compute row occupies the single MAC while it walks every
//   column and inner index, one product per cycle read from the A and B
//   stores while the output does not stall; req_bus.ready is low during that
//   walk, so the next request is taken after the row's last store read.
//   Each column's result follows its last inner product down the pipeline.
//   A row past rows_a gives no results and leaves req_bus.ready high.
//   Stall: when rsp_bus.ready is low with a result waiting, the whole MAC
//   pipeline and the store read ports freeze; nothing is lost.
//   Reset: synchronous; registers return to their default values, the
//   pipeline empties. Stores are not cleared and must be loaded before use.
//   Users write csr_* registers only with no request in flight; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module gemm_alpha_bias_engine_unit #(
   parameter int MAX_DIM = gab_pkg::DEFAULT_MAX_DIM
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   gab_req_if.sink                             req_bus,
   gab_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_wr_en,
   input  wire logic [gab_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gab_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import gab_pkg::*;

   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW          = $clog2(STORE_DEPTH);

   cfg_type       cfg_ff, cfg_in;
   tag_type       tag;
   logic          run, req_fire, in_range, ctrl_ready;
   logic          a_we, b_we, bias_we;
   logic [AW-1:0] wr_addr, a_addr, b_addr, bias_addr;
   logic [15:0]   a_rd, b_rd, bias_rd;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_A:      cfg_in.rows_a      = csr_wr_data[4:0];
            CSR_INNER_LEN:   cfg_in.inner_len   = csr_wr_data[4:0];
            CSR_COLS_B:      cfg_in.cols_b      = csr_wr_data[4:0];
            CSR_ALPHA_GAIN:  cfg_in.alpha_gain  = $signed(csr_wr_data);
            CSR_BIAS_BY_ROW: cfg_in.bias_by_row = csr_wr_data[0];
            CSR_BIAS_BY_COL: cfg_in.bias_by_col = csr_wr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // load path
   assign req_bus.ready = ctrl_ready;
   assign req_fire      = req_bus.valid && ctrl_ready;
   assign in_range      = 32'(req_bus.index) < 32'(STORE_DEPTH);
   assign wr_addr       = AW'(req_bus.index);
   assign a_we          = req_fire && in_range && (req_bus.kind == KIND_LOAD_A);
   assign b_we          = req_fire && in_range && (req_bus.kind == KIND_LOAD_B);
   assign bias_we       = req_fire && in_range && (req_bus.kind == KIND_LOAD_BIAS);

   gab_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .run       (run),
      .cfg       (cfg_ff),
      .req_fire  (req_fire),
      .req_kind  (req_bus.kind),
      .req_index (req_bus.index),
      .req_ready (ctrl_ready),
      .a_addr    (a_addr),
      .b_addr    (b_addr),
      .bias_addr (bias_addr),
      .tag       (tag)
   );

   // element stores
   gab_ram #(.DEPTH(STORE_DEPTH), .ADDR_W(AW)) u_a_store (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr),
      .wr_data (req_bus.value),
      .rd_en   (run),
      .rd_addr (a_addr),
      .rd_data (a_rd)
   );

   gab_ram #(.DEPTH(STORE_DEPTH), .ADDR_W(AW)) u_b_store (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (wr_addr),
      .wr_data (req_bus.value),
      .rd_en   (run),
      .rd_addr (b_addr),
      .rd_data (b_rd)
   );

   gab_ram #(.DEPTH(STORE_DEPTH), .ADDR_W(AW)) u_bias_store (
      .clock   (clock),
      .wr_en   (bias_we),
      .wr_addr (wr_addr),
      .wr_data (req_bus.value),
      .rd_en   (run),
      .rd_addr (bias_addr),
      .rd_data (bias_rd)
   );

   gab_mac #(.MAX_DIM(MAX_DIM)) u_mac (
      .clock      (clock),
      .reset      (reset),
      .alpha_gain (cfg_ff.alpha_gain),
      .tag_in     (tag),
      .a_rd       (a_rd),
      .b_rd       (b_rd),
      .bias_rd    (bias_rd),
      .run        (run),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

>>> hdl/gab_chk.sv
// ----------------------------------------------------------------------------
// gab_chk
// Port-level checks for the GEMM alpha/bias engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gab_chk (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic [1:0]         req_kind,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [3:0]         rsp_out_row,
   input wire logic [3:0]         rsp_out_col,
   input wire logic signed [31:0] rsp_out_value,
   input wire logic               rsp_saturated,
   input wire logic               rsp_last
);
   import gab_pkg::*;

   // reset empties the output
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a load never blocks the next request
   a_load_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind != KIND_COMPUTE) |=> req_ready)
      else $error("ready dropped after a load");

   // saturation flag only on a clipped value
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_out_value == 32'sh7fff_ffff) || (rsp_out_value == 32'sh8000_0000))
      else $error("saturated flag on an unclipped value");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_out_row, rsp_out_col, rsp_out_value, rsp_saturated, rsp_last}))
      else $error("result changed while stalled");

endmodule

bind gemm_alpha_bias_engine_unit gab_chk u_gab_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_kind      (req_bus.kind),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_out_row   (rsp_bus.out_row),
   .rsp_out_col   (rsp_bus.out_col),
   .rsp_out_value (rsp_bus.out_value),
   .rsp_saturated (rsp_bus.saturated),
   .rsp_last      (rsp_bus.last)
);

`default_nettype wire

>>> sim/gemm_alpha_bias_engine_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gemm_alpha_bias_engine_unit_tb
// Self-checking bench for the GEMM alpha/bias engine. Load and row-compute
// requests are streamed through the request channel under random gaps and
// result back-pressure. Each accepted load updates a local image of the
// three stores, and row computes are predicted element by element. Every
// result element is compared in order against the prediction.
// ----------------------------------------------------------------------------

module gemm_alpha_bias_engine_unit_tb;
   import gab_pkg::*;

   localparam int     MAX_DIM       = DEFAULT_MAX_DIM;
   localparam int     STORE_DEPTH   = MAX_DIM * MAX_DIM;
   localparam int     LIMIT_CYCLES  = 400000;
   localparam int     DRAIN_CYCLES  = 24;
   localparam int     LONG_HOLD     = 200;
   localparam int     RANDOM_PHASES = 8;
   localparam longint OUT_MAX       = (64'sd1 <<< 31) - 1;
   localparam longint OUT_MIN       = -(64'sd1 <<< 31);

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         index;
      logic signed [15:0] value;
   } gemm_req_type;

   typedef struct packed {
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [31:0] value;
      logic               sat;
      logic               last;
   } gemm_elem_type;

   logic clock;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   gab_req_if req_bus ();
   gab_rsp_if rsp_bus ();

   gemm_alpha_bias_engine_unit #(
      .MAX_DIM(MAX_DIM)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // pending requests and predicted result elements
   gemm_req_type  request_queue[$];
   gemm_elem_type expected_elements[$];

   // register shadow and store image used for prediction
   cfg_type            cfg_shadow = CFG_RESET;
   logic signed [15:0] store_image [3][STORE_DEPTH];
   // entries already scheduled for a write, kept by the stimulus side
   bit                 store_loaded[3][STORE_DEPTH];

   int unsigned gap_max     = 3;
   int unsigned stall_max   = 3;
   int unsigned req_gap     = 0;
   int unsigned rsp_pause   = 0;
   int unsigned hold_asked  = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left   = 0;
   int unsigned cycle_count = 0;

   int requests_accepted = 0;
   int rows_computed     = 0;
   int elements_checked  = 0;
   int settings_count    = 0;
   int mismatch_count    = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int dim_eff(input logic [4:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return int'(d);
   endfunction

   // apply one accepted request to the store image; row computes yield elements
   function automatic void apply_request(input gemm_req_type rq);
      int            nr, nk, nc, br, bc;
      longint        dot, sum;
      gemm_elem_type elem;
      nr = dim_eff(cfg_shadow.rows_a);
      nk = dim_eff(cfg_shadow.inner_len);
      nc = dim_eff(cfg_shadow.cols_b);
      if (rq.kind != KIND_COMPUTE) begin
         store_image[rq.kind][rq.index] = rq.value;
         return;
      end
      rows_computed++;
      if (rq.index >= nr) return;
      br = cfg_shadow.bias_by_row ? int'(rq.index) : 0;
      for (int c = 0; c < nc; c++) begin
         dot = 0;
         for (int k = 0; k < nk; k++)
            dot += longint'(store_image[KIND_LOAD_A][rq.index * MAX_DIM + k]) *
                   longint'(store_image[KIND_LOAD_B][k * MAX_DIM + c]);
         bc = cfg_shadow.bias_by_col ? c : 0;
         // Q24.24 scaled product floored to Q16.16, bias widened to Q16.16
         sum = ((longint'($signed(cfg_shadow.alpha_gain)) * dot) >>> 8) +
               (longint'(store_image[KIND_LOAD_BIAS][br * MAX_DIM + bc]) <<< 8);
         elem.sat = 1'b0;
         if (sum > OUT_MAX) begin
            sum      = OUT_MAX;
            elem.sat = 1'b1;
         end
         if (sum < OUT_MIN) begin
            sum      = OUT_MIN;
            elem.sat = 1'b1;
         end
         elem.row   = rq.index[3:0];
         elem.col   = 4'(c);
         elem.value = sum[31:0];
         elem.last  = (c == nc - 1);
         expected_elements.push_back(elem);
      end
   endfunction

   // request driver
   always @(posedge clock) begin : req_driver
      int unsigned  wait_n;
      gemm_req_type rq;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap       <= 0;
      end else begin
         wait_n = req_gap;
         if (req_bus.valid && req_bus.ready) begin
            rq.kind  = req_bus.kind;
            rq.index = req_bus.index;
            rq.value = req_bus.value;
            apply_request(rq);
            requests_accepted++;
            wait_n = $urandom_range(0, gap_max);
         end
         // a request not yet taken stays on the bus unchanged
         if (!req_bus.valid || req_bus.ready) begin
            if (wait_n != 0) begin
               req_bus.valid <= 1'b0;
               req_gap       <= wait_n - 1;
            end else if (request_queue.size() != 0) begin
               rq = request_queue.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.kind  <= rq.kind;
               req_bus.index <= rq.index;
               req_bus.value <= rq.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long result hold-off, armed from the stimulus process
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_served != hold_asked) begin
         hold_left   <= LONG_HOLD;
         hold_served <= hold_asked;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : rsp_monitor
      int unsigned   pause;
      gemm_elem_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_pause     <= 0;
      end else begin
         pause = rsp_pause;
         if (rsp_bus.valid && rsp_bus.ready) begin
            elements_checked++;
            if (expected_elements.size() == 0) begin
               $error("unexpected result element row %0d col %0d value %0d",
                      rsp_bus.out_row, rsp_bus.out_col, rsp_bus.out_value);
               mismatch_count++;
            end else begin
               want = expected_elements.pop_front();
               if (rsp_bus.out_row !== want.row) begin
                  $error("out_row: expected %0d, got %0d", want.row, rsp_bus.out_row);
                  mismatch_count++;
               end
               if (rsp_bus.out_col !== want.col) begin
                  $error("out_col: expected %0d, got %0d", want.col, rsp_bus.out_col);
                  mismatch_count++;
               end
               if (rsp_bus.out_value !== want.value) begin
                  $error("out_value: expected %0d, got %0d", want.value,
                         rsp_bus.out_value);
                  mismatch_count++;
               end
               if (rsp_bus.saturated !== want.sat) begin
                  $error("saturated: expected %0b, got %0b", want.sat,
                         rsp_bus.saturated);
                  mismatch_count++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_bus.last);
                  mismatch_count++;
               end
            end
            pause = $urandom_range(0, stall_max);
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (pause != 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_pause     <= pause - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("gemm_alpha_bias_engine_unit verification failed");
         $finish;
      end
   end

   // ---- stimulus helpers ----

   function automatic logic [15:0] rand_q88();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 1023) - 512);
   endfunction

   function automatic void push_load(input logic [1:0] kind, input int addr,
                                     input logic [15:0] val);
      gemm_req_type rq;
      rq.kind  = kind;
      rq.index = 8'(addr);
      rq.value = val;
      store_loaded[kind][addr] = 1'b1;
      request_queue.push_back(rq);
   endfunction

   function automatic void push_compute(input int row);
      gemm_req_type rq;
      rq.kind  = KIND_COMPUTE;
      rq.index = 8'(row);
      rq.value = 16'($urandom);
      request_queue.push_back(rq);
   endfunction

   // well-formed row: load whatever the row still lacks, then compute it
   function automatic void push_row(input int row);
      int nk, nc, br, addr;
      nk = dim_eff(cfg_shadow.inner_len);
      nc = dim_eff(cfg_shadow.cols_b);
      br = cfg_shadow.bias_by_row ? row : 0;
      for (int k = 0; k < nk; k++) begin
         addr = row * MAX_DIM + k;
         if (!store_loaded[KIND_LOAD_A][addr]) push_load(KIND_LOAD_A, addr, rand_q88());
      end
      for (int k = 0; k < nk; k++)
         for (int c = 0; c < nc; c++) begin
            addr = k * MAX_DIM + c;
            if (!store_loaded[KIND_LOAD_B][addr])
               push_load(KIND_LOAD_B, addr, rand_q88());
         end
      for (int c = 0; c < nc; c++) begin
         addr = br * MAX_DIM + (cfg_shadow.bias_by_col ? c : 0);
         if (!store_loaded[KIND_LOAD_BIAS][addr])
            push_load(KIND_LOAD_BIAS, addr, rand_q88());
      end
      push_compute(row);
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_ROWS_A:      cfg_shadow.rows_a      = data[4:0];
         CSR_INNER_LEN:   cfg_shadow.inner_len   = data[4:0];
         CSR_COLS_B:      cfg_shadow.cols_b      = data[4:0];
         CSR_ALPHA_GAIN:  cfg_shadow.alpha_gain  = data;
         CSR_BIAS_BY_ROW: cfg_shadow.bias_by_row = data[0];
         CSR_BIAS_BY_COL: cfg_shadow.bias_by_col = data[0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // junk upper bits check that only the low field bits are kept
   task automatic program_engine(input logic [4:0] nr, input logic [4:0] nk,
                                 input logic [4:0] nc, input logic [15:0] alpha,
                                 input logic by_row, input logic by_col,
                                 input bit junk);
      logic [15:0] hi;
      hi = junk ? 16'($urandom) : 16'h0;
      csr_write(CSR_ROWS_A,      {hi[15:5], nr});
      csr_write(CSR_INNER_LEN,   {hi[15:5], nk});
      csr_write(CSR_COLS_B,      {hi[15:5], nc});
      csr_write(CSR_ALPHA_GAIN,  alpha);
      csr_write(CSR_BIAS_BY_ROW, {hi[15:1], by_row});
      csr_write(CSR_BIAS_BY_COL, {hi[15:1], by_col});
      settings_count++;
   endtask

   // wait for the engine to drain, including loads and out-of-range rows
   task automatic wait_idle();
      do @(negedge clock);
      while (request_queue.size() != 0 || req_bus.valid ||
             expected_elements.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---- main sequence ----
   initial begin
      int          nr_eff, picks;
      logic [4:0]  nr, nk, nc;
      logic [15:0] alpha;

      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_ROWS_A;
      csr_wr_data   = '0;
      req_bus.valid = 1'b0;
      req_bus.kind  = KIND_LOAD_A;
      req_bus.index = '0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: 2x2x2 at maximum alpha, extreme operands, saturation both ways
      program_engine(5'd2, 5'd2, 5'd2, 16'h7FFF, 1'b1, 1'b1, 1'b0);
      @(negedge clock);
      push_load(KIND_LOAD_A,    0 * MAX_DIM + 0, 16'h7FFF);
      push_load(KIND_LOAD_A,    0 * MAX_DIM + 1, 16'h7FFF);
      push_load(KIND_LOAD_A,    1 * MAX_DIM + 0, 16'h8000);
      push_load(KIND_LOAD_A,    1 * MAX_DIM + 1, 16'h8000);
      push_load(KIND_LOAD_B,    0 * MAX_DIM + 0, 16'h7FFF);
      push_load(KIND_LOAD_B,    0 * MAX_DIM + 1, 16'h8000);
      push_load(KIND_LOAD_B,    1 * MAX_DIM + 0, 16'h7FFF);
      push_load(KIND_LOAD_B,    1 * MAX_DIM + 1, 16'h0001);
      push_load(KIND_LOAD_BIAS, 0 * MAX_DIM + 0, 16'h7FFF);
      push_load(KIND_LOAD_BIAS, 0 * MAX_DIM + 1, 16'h8000);
      push_load(KIND_LOAD_BIAS, 1 * MAX_DIM + 0, 16'h0000);
      push_load(KIND_LOAD_BIAS, 1 * MAX_DIM + 1, 16'hFFFF);
      push_load(KIND_LOAD_A,    STORE_DEPTH - 1, 16'h5A5A);
      push_compute(0);
      push_compute(1);
      // rows past rows_a give nothing
      push_compute(2);
      push_compute(STORE_DEPTH - 1);
      wait_idle();

      // directed: zero dimensions act as one, minimum alpha, fixed bias
      program_engine(5'd0, 5'd0, 5'd0, 16'h8000, 1'b0, 1'b0, 1'b0);
      for (int i = CSR_BIAS_BY_COL + 1; i < (1 << CSR_IDX_W); i++)
         csr_write(CSR_IDX_W'(i), 16'($urandom));
      @(negedge clock);
      push_compute(0);
      push_compute(1);
      wait_idle();

      // random phases: mostly well-formed rows, some noise loads and bad rows;
      // two phases use the full row width and the full inner length
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            2:       begin nr = 5'd16; nk = 5'd1;  nc = 5'd20; end
            5:       begin nr = 5'd31; nk = 5'd31; nc = 5'd1;  end
            6:       begin nr = 5'd0;  nk = 5'd0;  nc = 5'd0;  end
            default: begin
               nr = 5'($urandom_range(1, 4));
               nk = 5'($urandom_range(1, 4));
               nc = 5'($urandom_range(1, 4));
            end
         endcase
         case (p)
            0:       alpha = 16'sd256;
            4:       alpha = 16'h0000;
            7:       alpha = 16'($urandom);
            default: alpha = 16'($urandom_range(0, 1199) - 600);
         endcase
         program_engine(nr, nk, nc, alpha, p[0], p[1], p % 2 == 1);
         @(negedge clock);
         // hold results back while requests keep coming, so the engine backs up
         if (p == 3) hold_asked++;
         nr_eff = dim_eff(cfg_shadow.rows_a);
         picks  = (p == 5) ? 1 : ((p == 2) ? 2 : 6);
         for (int n = 0; n < picks; n++) begin
            if (p == 2 || p == 5) begin
               push_row($urandom_range(0, nr_eff - 1));
            end else begin
               case ($urandom_range(0, 9))
                  0:       push_load(2'($urandom_range(KIND_LOAD_A, KIND_LOAD_BIAS)),
                                     $urandom_range(0, STORE_DEPTH - 1), rand_q88());
                  1:       push_compute($urandom_range(nr_eff, STORE_DEPTH - 1));
                  default: push_row($urandom_range(0, nr_eff - 1));
               endcase
            end
         end
         wait_idle();
      end

      $display("Ran %0d requests (%0d row computes) over %0d register settings,",
               requests_accepted, rows_computed, settings_count);
      $display("checked %0d result elements against the predicted rows.",
               elements_checked);
      if (mismatch_count == 0)
         $display("gemm_alpha_bias_engine_unit verification clean");
      else
         $display("gemm_alpha_bias_engine_unit verification failed");
      $finish;
   end

endmodule
